// ===== hw/rtl/ptsn_pkg.sv =====
// Shared types, character codes and helpers for the path to short name converter.
`timescale 1ns / 1ps

package ptsn_pkg;

    localparam int C_NAME_LEN = 11;
    localparam int C_BASE_LEN = 8;
    localparam int C_POS_W    = 4;
    localparam int C_BASE_W   = 8 * C_BASE_LEN;
    localparam int C_EXT_W    = 8 * (C_NAME_LEN - C_BASE_LEN);
    localparam int C_DATA_W   = C_BASE_W + C_EXT_W;

    // tuser bit positions on the result channel.
    localparam int C_USER_ROOT = 0;
    localparam int C_USER_LONG = 1;
    localparam int C_USER_W    = 2;

    localparam logic [7:0] C_CH_NUL    = 8'h00;
    localparam logic [7:0] C_CH_SLASH  = 8'h2F;
    localparam logic [7:0] C_CH_BSLASH = 8'h5C;
    localparam logic [7:0] C_CH_DOT    = 8'h2E;
    localparam logic [7:0] C_CH_STAR   = 8'h2A;
    localparam logic [7:0] C_CH_SPACE  = 8'h20;
    localparam logic [7:0] C_CH_TILDE  = 8'h7E;
    localparam logic [7:0] C_CH_LOW_A  = 8'h61;
    localparam logic [7:0] C_CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] C_CASE_OFS  = 8'h20;

    typedef logic [C_POS_W-1:0] t_pos;

    // One path character held in the input register.
    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } t_beat;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= C_CH_LOW_A && c <= C_CH_LOW_Z) begin
            r = c - C_CASE_OFS;
        end
        return r;
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == C_CH_SLASH) || (c == C_CH_BSLASH);
    endfunction

endpackage

// ===== hw/rtl/path_to_short_name.sv =====
// Top level of the path to FAT 8.3 short name converter.
`timescale 1ns / 1ps
//
// A path streams in on the slave side, one byte per beat, a zero byte ending
// the path. Each finished segment leaves on the master side as one beat:
// tdata holds the eleven name bytes (base in bits 63:0, first byte highest;
// extension in bits 87:64), tlast marks the segment ended by the end of the
// path, tuser[0] flags a path of only separators (the name is then zero) and
// tuser[1] flags a long base that took the tilde form.
// Bytes that end no segment produce no output beat.
// Throughput is one byte per cycle while the receiver takes results. A result
// passes through the input register and then the name builder, which writes
// its whole update into the eleven-byte buffer and the result register
// together.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more byte; input tready then drops until the
// result is taken. Reset clears both registers' valid flags and returns the
// segment state to the start of a new path.
//
module path_to_short_name (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] ch
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [ptsn_pkg::C_DATA_W-1:0] o_m_tdata,   // [63:0] name_base, [87:64] name_ext
    output logic                          o_m_tlast,   // is_last
    output logic [ptsn_pkg::C_USER_W-1:0] o_m_tuser    // [0] is_root, [1] long_name
);
    import ptsn_pkg::*;

    t_beat beat;
    logic  adv;

    ptsn_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_adv      (adv),
        .o_beat     (beat)
    );

    ptsn_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_beat     (beat),
        .o_adv      (adv),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

// ===== hw/rtl/ptsn_in_reg.sv =====
// Input register stage: captures one path character per beat.
`timescale 1ns / 1ps

module ptsn_in_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_s_tdata,   // [7:0] ch
    input  logic          i_adv,
    output ptsn_pkg::t_beat o_beat
);
    import ptsn_pkg::*;

    logic       r_valid;
    logic [7:0] r_ch;

    // The register empties whenever the core takes its beat.
    assign o_s_tready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_ch <= i_s_tdata;
        end
    end

    assign o_beat.valid = r_valid;
    assign o_beat.ch    = r_ch;

endmodule

// ===== hw/rtl/ptsn_core.sv =====
// Name builder: segment state, eleven-byte name buffer and result register.
`timescale 1ns / 1ps

module ptsn_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ptsn_pkg::t_beat                     i_beat,
    output logic                                o_adv,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [ptsn_pkg::C_DATA_W-1:0]       o_m_tdata,  // [63:0] name_base, [87:64] name_ext
    output logic                                o_m_tlast,  // is_last
    output logic [ptsn_pkg::C_USER_W-1:0]       o_m_tuser   // [0] is_root, [1] long_name
);
    import ptsn_pkg::*;

    logic [7:0]          r_buf [C_NAME_LEN];
    logic [7:0]          n_buf [C_NAME_LEN];
    t_pos                r_pos, n_pos;
    logic                r_ext, n_ext;
    logic                r_long, n_long;
    logic                r_start, n_start;
    logic                r_saw_sep, n_saw_sep;
    logic                r_skip, n_skip;

    logic                r_out_valid;
    logic [C_DATA_W-1:0] r_out_data;
    logic                r_out_last;
    logic [C_USER_W-1:0] r_out_user;

    logic                take;
    logic                emit;
    logic                emit_last;
    logic                emit_root;
    logic [C_BASE_W-1:0] fin_base;
    logic [C_EXT_W-1:0]  fin_ext;
    t_pos                star_end;

    assign o_adv = !r_out_valid || i_m_tready;
    assign take  = i_beat.valid && o_adv;
    assign star_end = r_ext ? t_pos'(C_NAME_LEN) : t_pos'(C_BASE_LEN);

    // Finished name: unwritten tail is spaces, long names get the tilde form.
    always_comb begin
        logic [7:0] b;
        fin_base = '0;
        fin_ext  = '0;
        for (int k = 0; k < C_NAME_LEN; k++) begin
            b = (t_pos'(k) < r_pos) ? r_buf[k] : C_CH_SPACE;
            if (r_long && k == C_BASE_LEN - 2) begin
                b = C_CH_TILDE;
            end
            if (r_long && k == C_BASE_LEN - 1) begin
                b = C_CH_STAR;
            end
            if (k < C_BASE_LEN) begin
                fin_base[C_BASE_W-1-8*k -: 8] = b;
            end else begin
                fin_ext[C_EXT_W-1-8*(k-C_BASE_LEN) -: 8] = b;
            end
        end
    end

    always_comb begin
        n_buf     = r_buf;
        n_pos     = r_pos;
        n_ext     = r_ext;
        n_long    = r_long;
        n_start   = r_start;
        n_saw_sep = r_saw_sep;
        n_skip    = r_skip;
        emit      = 1'b0;
        emit_last = 1'b0;
        emit_root = 1'b0;
        if (take) begin
            if (i_beat.ch == C_CH_NUL) begin
                emit      = 1'b1;
                emit_last = 1'b1;
                emit_root = r_start && r_saw_sep;
                n_pos     = '0;
                n_ext     = 1'b0;
                n_long    = 1'b0;
                n_start   = 1'b1;
                n_saw_sep = 1'b0;
                n_skip    = 1'b0;
            end else if (is_sep(i_beat.ch)) begin
                if (r_start) begin
                    n_saw_sep = 1'b1;
                end else if (!r_skip) begin
                    emit   = 1'b1;
                    n_pos  = '0;
                    n_ext  = 1'b0;
                    n_long = 1'b0;
                    n_skip = 1'b1;
                end
            end else begin
                n_start = 1'b0;
                n_skip  = 1'b0;
                if (i_beat.ch == C_CH_DOT) begin
                    n_ext = 1'b1;
                    for (int k = 0; k < C_BASE_LEN; k++) begin
                        if (t_pos'(k) >= r_pos) begin
                            n_buf[k] = C_CH_SPACE;
                        end
                    end
                    n_pos = t_pos'(C_BASE_LEN);
                end else if (i_beat.ch == C_CH_STAR) begin
                    for (int k = 0; k < C_NAME_LEN; k++) begin
                        if (t_pos'(k) >= r_pos && t_pos'(k) < star_end) begin
                            n_buf[k] = C_CH_STAR;
                        end
                    end
                    if (r_pos < star_end) begin
                        n_pos = star_end;
                    end
                end else if (!r_ext && r_pos >= t_pos'(C_BASE_LEN)) begin
                    n_long = 1'b1;
                end else if (r_pos < t_pos'(C_NAME_LEN)) begin
                    for (int k = 0; k < C_NAME_LEN; k++) begin
                        if (t_pos'(k) == r_pos) begin
                            n_buf[k] = to_upper(i_beat.ch);
                        end
                    end
                    n_pos = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_ext     <= 1'b0;
            r_long    <= 1'b0;
            r_start   <= 1'b1;
            r_saw_sep <= 1'b0;
            r_skip    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_ext     <= n_ext;
            r_long    <= n_long;
            r_start   <= n_start;
            r_saw_sep <= n_saw_sep;
            r_skip    <= n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_adv) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_data              <= emit_root ? '0 : {fin_ext, fin_base};
            r_out_last              <= emit_last;
            r_out_user[C_USER_ROOT] <= emit_root;
            r_out_user[C_USER_LONG] <= !emit_root && r_long;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

endmodule

// ===== hw/rtl/ptsn_checker.sv =====
// Port-level checks for the path to short name converter, bound to the top level.
`timescale 1ns / 1ps

module ptsn_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [ptsn_pkg::C_DATA_W-1:0] o_m_tdata,
    input logic                          o_m_tlast,
    input logic [ptsn_pkg::C_USER_W-1:0] o_m_tuser
);
    import ptsn_pkg::*;

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("result beat changed while stalled");

    // A root report can only come from the end of a path.
    a_root_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[C_USER_ROOT] |-> o_m_tlast)
        else $error("root report without end of path");

    a_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[C_USER_ROOT] |->
            o_m_tdata == '0 && !o_m_tuser[C_USER_LONG])
        else $error("root report with a name or long flag");

    // Long names always carry the tilde form in base bytes six and seven.
    a_long_tilde: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[C_USER_LONG] |->
            o_m_tdata[15:8] == C_CH_TILDE && o_m_tdata[7:0] == C_CH_STAR)
        else $error("long name without tilde form");

endmodule

bind path_to_short_name ptsn_checker u_ptsn_checker (.*);

// ===== sim/path_to_short_name_tb.sv =====
// Self-checking testbench for the path to FAT 8.3 short name converter.
`timescale 1ns / 1ps

module path_to_short_name_tb;
    import ptsn_pkg::*;

    localparam int STIM_BYTES  = 1700;
    localparam int IDLE_LIMIT  = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [63:0] base;
        logic [23:0] ext;
        logic        last;
        logic        root;
        logic        lng;
    } t_short_name;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [7:0]            i_s_tdata = 8'h00;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [C_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tlast;
    logic [C_USER_W-1:0]   o_m_tuser;

    path_to_short_name uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // Path bytes waiting to be sent and short names waiting to arrive.
    logic [7:0]  path_q[$];
    t_short_name name_q[$];

    // Shadow of the name builder.
    logic [7:0] nm [0:C_NAME_LEN-1];
    logic [3:0] wr_pos;
    logic       seg_ext;
    logic       seg_long;
    logic       path_fresh;
    logic       lead_sep;
    logic       sep_run;

    int errors;
    int names_checked;
    int bytes_taken;
    int paths_seen;
    int roots_seen;
    int longs_seen;
    int hold_left;
    int stall_left;
    int src_wait;
    int burst_left;
    int idle_cycles;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic void fill_name(input int upto, input logic [7:0] v);
        while (wr_pos < upto && wr_pos < C_NAME_LEN) begin
            nm[wr_pos] = v;
            wr_pos++;
        end
    endfunction

    function automatic void new_segment();
        wr_pos   = '0;
        seg_ext  = 1'b0;
        seg_long = 1'b0;
    endfunction

    function automatic void clear_path();
        new_segment();
        path_fresh = 1'b1;
        lead_sep   = 1'b0;
        sep_run    = 1'b0;
    endfunction

    function automatic t_short_name make_name(input logic last, input logic root);
        t_short_name r;
        r = '0;
        if (!root) begin
            fill_name(C_NAME_LEN, C_CH_SPACE);
            if (seg_long) begin
                nm[6] = C_CH_TILDE;
                nm[7] = C_CH_STAR;
            end
            for (int k = 0; k < C_BASE_LEN; k++) r.base = {r.base[55:0], nm[k]};
            for (int k = C_BASE_LEN; k < C_NAME_LEN; k++) r.ext = {r.ext[15:0], nm[k]};
        end
        r.last = last;
        r.root = root;
        r.lng  = !root && seg_long;
        return r;
    endfunction

    function automatic void predict_char(input logic [7:0] c);
        t_short_name r;
        logic [7:0]  u;
        u = c;
        bytes_taken++;
        if (c == C_CH_NUL) begin
            r = make_name(1'b1, path_fresh && lead_sep);
            name_q.push_back(r);
            paths_seen++;
            if (r.root) roots_seen++;
            if (r.lng) longs_seen++;
            clear_path();
        end else if (c == C_CH_SLASH || c == C_CH_BSLASH) begin
            if (path_fresh) begin
                lead_sep = 1'b1;
            end else if (!sep_run) begin
                r = make_name(1'b0, 1'b0);
                name_q.push_back(r);
                if (r.lng) longs_seen++;
                new_segment();
                sep_run = 1'b1;
            end
        end else begin
            path_fresh = 1'b0;
            sep_run    = 1'b0;
            if (c == C_CH_DOT) begin
                seg_ext = 1'b1;
                fill_name(C_BASE_LEN, C_CH_SPACE);
                wr_pos = 4'(C_BASE_LEN);
            end else if (c == C_CH_STAR) begin
                fill_name(seg_ext ? C_NAME_LEN : C_BASE_LEN, C_CH_STAR);
            end else if (seg_ext && wr_pos >= C_NAME_LEN) begin
                // Extension is full; the byte is dropped.
            end else if (!seg_ext && wr_pos >= C_BASE_LEN) begin
                seg_long = 1'b1;
            end else begin
                if (c >= C_CH_LOW_A && c <= C_CH_LOW_Z) u = c - C_CASE_OFS;
                nm[wr_pos] = u;
                wr_pos++;
            end
        end
    endfunction

    function automatic logic [7:0] pick_sep();
        return $urandom_range(0, 1) ? C_CH_SLASH : C_CH_BSLASH;
    endfunction

    function automatic logic [7:0] pick_name_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 60) return 8'($urandom_range(8'h30, 8'h5A));
        if (r < 68) return C_CH_DOT;
        if (r < 73) return C_CH_STAR;
        if (r < 90) return 8'($urandom_range(8'h21, 8'h7E));
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void push_path(input string s);
        for (int k = 0; k < s.len(); k++) path_q.push_back(s[k]);
        path_q.push_back(C_CH_NUL);
    endfunction

    // Mostly well-formed paths with random names, now and then pure noise.
    function automatic void add_random_path();
        int nseg;
        int len;
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) begin
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++) begin
                path_q.push_back($urandom_range(0, 3) == 0 ? pick_sep()
                                                          : 8'($urandom_range(1, 255)));
            end
        end else if (r == 2) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) path_q.push_back(pick_sep());
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) path_q.push_back(pick_sep());
            end
            nseg = $urandom_range(1, 4);
            for (int s = 0; s < nseg; s++) begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) path_q.push_back(pick_name_char());
                if (s < nseg - 1 || $urandom_range(0, 5) == 0) begin
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
                    for (int k = 0; k < len; k++) path_q.push_back(pick_sep());
                end
            end
        end
        path_q.push_back(C_CH_NUL);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sender: one beat per path byte, with random gaps and gap-free bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (src_wait > 0) begin
                src_wait = src_wait - 1;
                i_s_tvalid <= 1'b0;
            end else if (path_q.size() > 0) begin
                i_s_tdata  <= path_q.pop_front();
                i_s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left = burst_left - 1;
                    src_wait = 0;
                end else begin
                    src_wait = pick_gap();
                    if ($urandom_range(0, 99) == 0) burst_left = $urandom_range(50, 200);
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver and checker: compare each result beat, then predict from the input beat.
    always @(posedge i_clk) begin
        t_short_name got;
        t_short_name exp_name;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.base = o_m_tdata[63:0];
                got.ext  = o_m_tdata[87:64];
                got.last = o_m_tlast;
                got.root = o_m_tuser[C_USER_ROOT];
                got.lng  = o_m_tuser[C_USER_LONG];
                if (name_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, actual %h", $time, got);
                end else begin
                    exp_name = name_q.pop_front();
                    if (got.base !== exp_name.base) begin
                        errors++;
                        $display("%0t: name_base expected %h actual %h",
                                 $time, exp_name.base, got.base);
                    end
                    if (got.ext !== exp_name.ext) begin
                        errors++;
                        $display("%0t: name_ext expected %h actual %h",
                                 $time, exp_name.ext, got.ext);
                    end
                    if (got.last !== exp_name.last) begin
                        errors++;
                        $display("%0t: is_last expected %b actual %b",
                                 $time, exp_name.last, got.last);
                    end
                    if (got.root !== exp_name.root) begin
                        errors++;
                        $display("%0t: is_root expected %b actual %b",
                                 $time, exp_name.root, got.root);
                    end
                    if (got.lng !== exp_name.lng) begin
                        errors++;
                        $display("%0t: long_name expected %b actual %b",
                                 $time, exp_name.lng, got.lng);
                    end
                end
                names_checked++;
                // Long hold-offs so the block fills up and stalls its input.
                if (names_checked == 150 || names_checked == 700) hold_left = HOLD_CYCLES;
            end
            if (i_s_tvalid && o_s_tready) predict_char(i_s_tdata);

            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // Watchdog on cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        errors = 0;
        names_checked = 0;
        bytes_taken = 0;
        paths_seen = 0;
        roots_seen = 0;
        longs_seen = 0;
        hold_left = 0;
        stall_left = 0;
        src_wait = 0;
        burst_left = 0;
        idle_cycles = 0;
        for (int k = 0; k < C_NAME_LEN; k++) nm[k] = '0;
        clear_path();

        // Root, empty path, trailing and repeated separators, dropped
        // extension bytes, stars in base and extension, high and low bytes.
        push_path("/\\");
        push_path("");
        push_path("\\z.txtx//");
        push_path("ab*c.d*");
        path_q.push_back(8'hFF);
        path_q.push_back(8'h01);
        path_q.push_back(C_CH_NUL);
        while (path_q.size() < STIM_BYTES) add_random_path();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (path_q.size() > 0 || i_s_tvalid || name_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (name_q.size() != 0) begin
            errors++;
            $display("%0t: %0d short names never arrived", $time, name_q.size());
        end

        $display("Sent %0d path bytes in %0d paths; checked %0d short names,",
                 bytes_taken, paths_seen, names_checked);
        $display("%0d of them root paths and %0d in tilde form.", roots_seen, longs_seen);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
